// ===== rtl/i2cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants for the I2C bit-level master engine.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int unsigned MaxBlockLength = 32;
    localparam int unsigned CountWidth = 16;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_BEGIN = 2'd1;
    localparam logic [1:0] ACT_TXB   = 2'd2;

    localparam logic [1:0] CFG_DELAY   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_STRETCH = 2'd2;
    localparam logic [1:0] CFG_RETRIES = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ADDRNAK = 3'd1;
    localparam logic [2:0] ST_DATANAK = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_BADLEN  = 3'd4;

    localparam int unsigned F_READ = 0;
    localparam int unsigned F_TEN = 1;
    localparam int unsigned F_IGNORE = 2;
    localparam int unsigned F_NOSTART = 3;
    localparam int unsigned F_REV = 4;
    localparam int unsigned F_NOACK = 5;
    localparam int unsigned F_LEN = 6;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b0000000001,
        PH_WAIT_MSG = 10'b0000000010,
        PH_WAIT_TX  = 10'b0000000100,
        PH_START    = 10'b0000001000,
        PH_REPSTART = 10'b0000010000,
        PH_STOP     = 10'b0000100000,
        PH_GAP      = 10'b0001000000,
        PH_OUTB     = 10'b0010000000,
        PH_INB      = 10'b0100000000,
        PH_ACK      = 10'b1000000000
    } t_phase;

    typedef enum logic [2:0] {
        SG_ADDR1, SG_ADDR2, SG_ADDR3, SG_DATA, SG_END
    } t_stage;

    typedef struct packed {
        logic [1:0]  action;
        logic        scl_in;
        logic        sda_in;
        logic [9:0]  target_addr;
        logic [7:0]  tx_byte;
        logic [6:0]  message_flags;
        logic [15:0] byte_count;
        logic        last_message;
    } t_in_item;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic        tx_request;
        logic        message_done;
        logic        transfer_done;
        logic [2:0]  status;
        logic [15:0] messages_done;
        logic        busy_res;
    } t_out_item;

endpackage

// ===== rtl/i2cbm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_in_if
// Valid/ready channel carrying one command or tick item.
// ----------------------------------------------------------------------------
interface i2cbm_in_if import i2cbm_pkg::*; ;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2cbm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_out_if
// Valid/ready channel carrying one engine result item.
// ----------------------------------------------------------------------------
interface i2cbm_out_if import i2cbm_pkg::*; ;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/i2c_bit_master_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_master_engine
// I2C master bit engine stepped by prescaler ticks and commands.
//
//  channel   dir  item
//  s_in      in   tick with line samples / begin message / transmit byte
//  m_out     out  line drives, rx byte, status, counters
//  cfg       in   register write (index, data)
//
// one item in per cycle unless a stalled result blocks it, its result registered in the output register
// the state update for an item is one combinational pass into the state regs
// input is taken whenever the output register is empty or being drained
// synchronous active-low reset returns to idle with lines released
// ----------------------------------------------------------------------------
module i2c_bit_master_engine import i2cbm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbm_in_if.sink    s_in,
    i2cbm_out_if.source m_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    localparam logic [CountWidth-1:0] CountMax = '1;

    logic [15:0] r_delay_cfg;
    logic [23:0] r_tmo_cfg;
    logic        r_chk_cfg;
    logic [2:0]  r_retry_cfg;

    t_phase r_phase, n_phase;
    t_stage r_stage, n_stage;
    logic [15:0] r_delay, n_delay;
    logic [23:0] r_scnt, n_scnt;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [CountWidth-1:0] r_left, n_left;
    logic [2:0]  r_retry, n_retry;
    logic [7:0]  r_abyte, n_abyte;
    logic [6:0]  r_flags, n_flags;
    logic        r_intr, n_intr;
    logic        r_frd, n_frd;
    logic [15:0] r_total, n_total;
    logic        r_scl, n_scl, r_sda, n_sda;
    logic [1:0]  r_step, n_step;
    logic        r_last, n_last;
    logic [9:0]  r_addr, n_addr;
    logic [2:0]  r_status, n_status;
    logic [7:0]  r_rx, n_rx;
    logic        r_samp, n_samp;
    logic        r_str, n_str, r_fatal, n_fatal, r_rtry, n_rtry;
    logic        n_rxp, n_done;

    logic        r_ov;
    t_out_item   r_out;
    logic        accept;

    assign s_in.ready = !r_ov || m_out.ready;
    assign accept = s_in.valid && s_in.ready;
    assign m_out.valid = r_ov;
    assign m_out.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_cfg <= 16'd10;
            r_tmo_cfg <= 24'd100000;
            r_chk_cfg <= 1'b1;
            r_retry_cfg <= 3'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY: r_delay_cfg <= i_cfg_data[15:0];
                CFG_TIMEOUT: r_tmo_cfg <= i_cfg_data;
                CFG_STRETCH: r_chk_cfg <= i_cfg_data[0];
                CFG_RETRIES: r_retry_cfg <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic [15:0] full_d, half_up, half_dn;
    assign full_d = (r_delay_cfg == 16'd0) ? 16'd1 : r_delay_cfg;
    assign half_up = (r_delay_cfg[15:1] + {15'd0, r_delay_cfg[0]} == 16'd0) ? 16'd1
                     : 16'(r_delay_cfg[15:1] + {15'd0, r_delay_cfg[0]});
    assign half_dn = (r_delay_cfg[15:1] == 15'd0) ? 16'd1 : {1'b0, r_delay_cfg[15:1]};

    always_comb begin
        t_in_item in;
        logic [CountWidth:0] sum;
        logic ok, ack;
        logic [2:0] limit;
        logic go_stop, go_rep, go_start, go_outb, go_inb, go_ack, ack_v, nxt, mcomp;
        logic [7:0] ob;
        logic fail_v;
        logic [2:0] fail_c;
        logic seg_done, snow;
        logic [7:0] shf;
        logic [CountWidth-1:0] left_tmp;
        logic [3:0] bi;

        in = s_in.data;
        n_phase = r_phase; n_stage = r_stage; n_delay = r_delay; n_scnt = r_scnt;
        n_bit = r_bit; n_shift = r_shift; n_left = r_left; n_retry = r_retry;
        n_abyte = r_abyte; n_flags = r_flags; n_intr = r_intr; n_frd = r_frd;
        n_total = r_total; n_scl = r_scl; n_sda = r_sda; n_step = r_step;
        n_last = r_last; n_addr = r_addr; n_status = r_status; n_rx = r_rx;
        n_samp = r_samp; n_str = r_str; n_fatal = r_fatal; n_rtry = r_rtry;
        n_rxp = 1'b0; n_done = 1'b0;
        sum = '0; ok = 1'b0; ack = 1'b0; limit = '0; shf = '0;
        go_stop = 1'b0; go_rep = 1'b0; go_start = 1'b0; go_outb = 1'b0; go_inb = 1'b0;
        go_ack = 1'b0; ack_v = 1'b0; nxt = 1'b0; mcomp = 1'b0; ob = '0;
        fail_v = 1'b0; fail_c = ST_OK; seg_done = 1'b0; snow = in.sda_in;
        left_tmp = r_left; bi = r_bit;

        if (accept) begin
            case (in.action)
                ACT_TICK: begin
                    if (!(r_phase == PH_IDLE || r_phase == PH_WAIT_MSG
                          || r_phase == PH_WAIT_TX)) begin
                        if (r_str) begin
                            if (in.scl_in) begin
                                n_str = 1'b0;
                                n_delay = full_d;
                            end else begin
                                n_scnt = r_scnt + 24'd1;
                                if (n_scnt >= ((r_tmo_cfg == 24'd0) ? 24'd1 : r_tmo_cfg)) begin
                                    n_str = 1'b0;
                                    if (r_fatal) begin
                                        fail_v = 1'b1; fail_c = ST_TIMEOUT;
                                    end else begin
                                        seg_done = 1'b1;
                                    end
                                end
                            end
                        end else begin
                            if (r_delay != 16'd0) n_delay = r_delay - 16'd1;
                            if (n_delay == 16'd0) seg_done = 1'b1;
                        end
                    end
                end
                ACT_BEGIN: begin
                    if (r_phase == PH_IDLE || r_phase == PH_WAIT_MSG) begin
                        n_flags = in.message_flags;
                        n_addr = in.target_addr;
                        n_last = in.last_message;
                        n_left = CountWidth'(in.byte_count);
                        left_tmp = n_left;
                        n_frd = 1'b0; n_retry = '0; n_rtry = 1'b0;
                        if (in.message_flags[F_TEN]) begin
                            n_abyte = 8'hf0 | ({5'd0, in.target_addr[9:7]} & 8'h06);
                        end else begin
                            n_abyte = {in.target_addr[6:0], 1'b0};
                            if (in.message_flags[F_READ]) n_abyte[0] = 1'b1;
                            if (in.message_flags[F_REV]) n_abyte[0] = ~n_abyte[0];
                        end
                        if (r_phase == PH_IDLE) begin
                            n_intr = 1'b1; n_status = ST_OK; n_total = '0;
                            n_stage = in.message_flags[F_NOSTART] ? SG_DATA : SG_ADDR1;
                            go_start = 1'b1;
                        end else if (in.message_flags[F_NOSTART]) begin
                            n_stage = SG_DATA; nxt = 1'b1;
                        end else begin
                            n_stage = SG_ADDR1; go_rep = 1'b1;
                        end
                    end
                end
                ACT_TXB: begin
                    if (r_phase == PH_WAIT_TX) begin
                        go_outb = 1'b1; ob = in.tx_byte;
                    end
                end
                default: ;
            endcase
        end

        if (seg_done) begin
            case (r_phase)
                PH_START: begin
                    if (r_step == 2'd0) begin
                        n_step = 2'd1; n_scl = 1'b0; n_str = 1'b0; n_delay = half_dn;
                    end else if (r_stage == SG_DATA) nxt = 1'b1;
                    else begin go_outb = 1'b1; ob = r_abyte; end
                end
                PH_REPSTART: begin
                    case (r_step)
                        2'd0: begin
                            n_step = 2'd1; n_scl = 1'b1; n_sda = 1'b1; n_fatal = 1'b0;
                            n_scnt = '0; n_str = r_chk_cfg;
                            n_delay = r_chk_cfg ? 16'd0 : full_d;
                        end
                        2'd1: begin
                            n_step = 2'd2; n_scl = 1'b1; n_sda = 1'b0; n_str = 1'b0;
                            n_delay = full_d;
                        end
                        2'd2: begin
                            n_step = 2'd3; n_scl = 1'b0; n_sda = 1'b0; n_str = 1'b0;
                            n_delay = half_dn;
                        end
                        default: begin
                            if (r_stage == SG_DATA) nxt = 1'b1;
                            else begin go_outb = 1'b1; ob = r_abyte; end
                        end
                    endcase
                end
                PH_STOP: begin
                    if (r_step == 2'd0) begin
                        n_step = 2'd1; n_scl = 1'b1; n_sda = 1'b0; n_fatal = 1'b0;
                        n_scnt = '0; n_str = r_chk_cfg;
                        n_delay = r_chk_cfg ? 16'd0 : full_d;
                    end else if (r_step == 2'd1) begin
                        n_step = 2'd2; n_scl = 1'b1; n_sda = 1'b1; n_str = 1'b0;
                        n_delay = full_d;
                    end else if (r_rtry) begin
                        n_phase = PH_GAP; n_str = 1'b0; n_delay = full_d;
                    end else begin
                        n_phase = PH_IDLE; n_intr = 1'b0; n_done = 1'b1;
                    end
                end
                PH_GAP: begin
                    n_rtry = 1'b0; go_start = 1'b1;
                end
                PH_OUTB: begin
                    if (r_step == 2'd0) begin
                        n_step = 2'd1; n_scl = 1'b1; n_fatal = 1'b1;
                        n_scnt = '0; n_str = r_chk_cfg;
                        n_delay = r_chk_cfg ? 16'd0 : full_d;
                    end else if (r_step == 2'd1) begin
                        n_samp = snow; n_step = 2'd2; n_scl = 1'b0; n_str = 1'b0;
                        n_delay = half_dn;
                    end else if (r_bit < 4'd8) begin
                        bi = r_bit + 4'd1;
                        n_bit = bi;
                        n_sda = (bi < 4'd8) ? r_shift[3'(4'd7 - bi)] : 1'b1;
                        n_step = 2'd0; n_str = 1'b0; n_delay = half_up;
                    end else begin
                        ack = (r_samp == 1'b0);
                        ok = ack || r_flags[F_IGNORE];
                        limit = r_flags[F_IGNORE] ? 3'd0 : r_retry_cfg;
                        if (r_stage == SG_ADDR1 || r_stage == SG_ADDR3) begin
                            if (!ack && r_retry < limit) begin
                                n_retry = r_retry + 3'd1; n_rtry = 1'b1; go_stop = 1'b1;
                            end else if (!ok) begin
                                fail_v = 1'b1; fail_c = ST_ADDRNAK;
                            end else if (r_stage == SG_ADDR1 && r_flags[F_TEN]) begin
                                n_stage = SG_ADDR2; go_outb = 1'b1; ob = r_addr[7:0];
                            end else begin
                                n_stage = SG_DATA; nxt = 1'b1;
                            end
                        end else if (r_stage == SG_ADDR2) begin
                            if (!ok) begin
                                fail_v = 1'b1; fail_c = ST_ADDRNAK;
                            end else if (r_flags[F_READ]) begin
                                n_stage = SG_ADDR3; n_abyte = r_abyte | 8'h01;
                                n_retry = '0; go_rep = 1'b1;
                            end else begin
                                n_stage = SG_DATA; nxt = 1'b1;
                            end
                        end else begin
                            if (!ok) begin
                                fail_v = 1'b1; fail_c = ST_DATANAK;
                            end else begin
                                if (r_left != '0) left_tmp = r_left - 1'b1;
                                n_left = left_tmp; nxt = 1'b1;
                            end
                        end
                    end
                end
                PH_INB: begin
                    if (r_step == 2'd1) begin
                        n_shift = {r_shift[6:0], snow}; n_step = 2'd2;
                        n_scl = 1'b0; n_sda = 1'b1; n_str = 1'b0;
                        n_delay = (r_bit == 4'd7) ? half_dn : full_d;
                    end else if (r_step == 2'd2 && r_bit + 4'd1 >= 4'd8) begin
                        n_bit = r_bit + 4'd1;
                        shf = r_shift;
                        n_rx = shf; n_rxp = 1'b1;
                        if (r_left != '0) left_tmp = r_left - 1'b1;
                        n_left = left_tmp;
                        if (r_flags[F_LEN] && !r_frd) begin
                            n_frd = 1'b1;
                            if (shf == 8'd0 || 32'(shf) > MaxBlockLength) begin
                                n_status = ST_BADLEN;
                                if (r_flags[F_NOACK]) begin
                                    fail_v = 1'b1; fail_c = ST_BADLEN;
                                end else begin
                                    go_ack = 1'b1; ack_v = 1'b0;
                                end
                            end else begin
                                sum = {1'b0, left_tmp} + (CountWidth+1)'(shf);
                                left_tmp = sum[CountWidth] ? CountMax : sum[CountWidth-1:0];
                                n_left = left_tmp;
                                if (r_flags[F_NOACK]) nxt = 1'b1;
                                else begin go_ack = 1'b1; ack_v = (left_tmp != '0); end
                            end
                        end else if (r_flags[F_NOACK]) nxt = 1'b1;
                        else begin go_ack = 1'b1; ack_v = (left_tmp != '0); end
                    end else begin
                        if (r_step == 2'd2) n_bit = r_bit + 4'd1;
                        n_step = 2'd1; n_scl = 1'b1; n_sda = 1'b1; n_fatal = 1'b1;
                        n_scnt = '0; n_str = r_chk_cfg;
                        n_delay = r_chk_cfg ? 16'd0 : full_d;
                    end
                end
                PH_ACK: begin
                    if (r_step == 2'd0) begin
                        n_step = 2'd1; n_scl = 1'b1; n_fatal = 1'b1;
                        n_scnt = '0; n_str = r_chk_cfg;
                        n_delay = r_chk_cfg ? 16'd0 : full_d;
                    end else if (r_step == 2'd1) begin
                        n_step = 2'd2; n_scl = 1'b0; n_str = 1'b0; n_delay = half_dn;
                    end else if (r_status != ST_OK) begin
                        fail_v = 1'b1; fail_c = r_status;
                    end else nxt = 1'b1;
                end
                default: ;
            endcase
        end

        if (nxt) begin
            if (left_tmp == '0) mcomp = 1'b1;
            else if (n_flags[F_READ]) go_inb = 1'b1;
            else n_phase = PH_WAIT_TX;
        end
        if (mcomp) begin
            if (n_total != 16'hffff) n_total = n_total + 16'd1;
            if (n_last) begin n_stage = SG_END; go_stop = 1'b1; end
            else n_phase = PH_WAIT_MSG;
        end
        if (fail_v) begin
            n_status = fail_c; n_stage = SG_END; n_rtry = 1'b0; go_stop = 1'b1;
        end
        if (go_start) begin
            n_phase = PH_START; n_step = 2'd0; n_sda = 1'b0; n_str = 1'b0;
            n_delay = full_d;
        end
        if (go_rep) begin
            n_phase = PH_REPSTART; n_step = 2'd0; n_sda = 1'b1; n_str = 1'b0;
            n_delay = half_up;
        end
        if (go_stop) begin
            n_phase = PH_STOP; n_step = 2'd0; n_sda = 1'b0; n_str = 1'b0;
            n_delay = half_up;
        end
        if (go_outb) begin
            n_phase = PH_OUTB; n_shift = ob; n_bit = '0; n_step = 2'd0;
            n_sda = ob[7]; n_str = 1'b0; n_delay = half_up;
        end
        if (go_inb) begin
            n_phase = PH_INB; n_shift = '0; n_bit = '0; n_step = 2'd0;
            n_sda = 1'b1; n_str = 1'b0; n_delay = half_up;
        end
        if (go_ack) begin
            n_phase = PH_ACK; n_step = 2'd0; n_sda = ack_v ? 1'b0 : n_sda;
            n_str = 1'b0; n_delay = half_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_stage <= SG_END; r_delay <= '0; r_scnt <= '0;
            r_bit <= '0; r_shift <= '0; r_left <= '0; r_retry <= '0; r_abyte <= '0;
            r_flags <= '0; r_intr <= 1'b0; r_frd <= 1'b0; r_total <= '0;
            r_scl <= 1'b1; r_sda <= 1'b1; r_step <= '0; r_last <= 1'b0; r_addr <= '0;
            r_status <= ST_OK; r_rx <= '0; r_samp <= 1'b0; r_str <= 1'b0;
            r_fatal <= 1'b0; r_rtry <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase; r_stage <= n_stage; r_delay <= n_delay;
                r_scnt <= n_scnt; r_bit <= n_bit; r_shift <= n_shift; r_left <= n_left;
                r_retry <= n_retry; r_abyte <= n_abyte; r_flags <= n_flags;
                r_intr <= n_intr; r_frd <= n_frd; r_total <= n_total; r_scl <= n_scl;
                r_sda <= n_sda; r_step <= n_step; r_last <= n_last; r_addr <= n_addr;
                r_status <= n_status; r_rx <= n_rx; r_samp <= n_samp; r_str <= n_str;
                r_fatal <= n_fatal; r_rtry <= n_rtry;
            end
            if (accept) r_ov <= 1'b1;
            else if (m_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.scl_out <= n_scl;
            r_out.sda_out <= n_sda;
            r_out.rx_byte <= n_rx;
            r_out.rx_valid <= n_rxp;
            r_out.tx_request <= (n_phase == PH_WAIT_TX);
            r_out.message_done <= (n_phase == PH_WAIT_MSG);
            r_out.transfer_done <= n_done;
            r_out.status <= n_status;
            r_out.messages_done <= n_total;
            r_out.busy_res <= !(n_phase == PH_IDLE || n_phase == PH_WAIT_MSG);
        end
    end

    // idle means no transfer in progress
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_intr)
        else $error("idle with transfer flag set");
    // a stretch wait only happens with SCL released
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_str |-> r_scl)
        else $error("stretching while driving scl low");
    // output register holds while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_out.ready) |=> (r_ov && $stable(r_out)))
        else $error("result lost under stall");
    // an item is never taken while a stalled result blocks the register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_out.ready) |-> !s_in.ready)
        else $error("input taken over a stalled result");

endmodule
